/* sv/mfe_pkg.sv */
// ============================================================================
// mfe_pkg: shared types, codes and constants for the floor-extract store
// Holds the controller state type, the status and action codes, the control
// group that the controller hands to every cell, and the elaboration-time
// helpers that size the pipelined result tree.
// ============================================================================
package mfe_pkg;

    // Default sizes of the store.
    localparam int DEF_CAPACITY   = 1024;
    localparam int DEF_VALUE_BITS = 32;

    // Widths of the fixed stream fields.
    localparam int VALUE_FIELD_BITS  = 32;
    localparam int STATUS_FIELD_BITS = 2;

    // Item kinds carried on the input tuser.
    localparam logic ACTION_INSERT = 1'b0;
    localparam logic ACTION_QUERY  = 1'b1;

    // Result status codes carried on the output tuser.
    localparam logic [STATUS_FIELD_BITS-1:0] STATUS_INSERTED = 2'd0;
    localparam logic [STATUS_FIELD_BITS-1:0] STATUS_FULL     = 2'd1;
    localparam logic [STATUS_FIELD_BITS-1:0] STATUS_FOUND    = 2'd2;
    localparam logic [STATUS_FIELD_BITS-1:0] STATUS_NONE     = 2'd3;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_TREE,
        ST_OUT
    } state_t;

    // Control group broadcast to every cell of the chain.
    typedef struct packed {
        logic cmp_en;   // capture the compare flags of a new transaction
        logic ins_en;   // open a gap and write the broadcast value
        logic del_en;   // close the gap left by the extracted value
    } cell_ctl_t;

    // Number of nodes on a given level of a radix-4 reduction tree.
    function automatic int tree_level_count(input int leaves, input int level);
        int c;
        c = leaves;
        for (int k = 0; k < level; k++) begin
            c = (c + 3) >> 2;
        end
        return c;
    endfunction

    // Number of registered reduction levels above the leaves.
    function automatic int tree_levels(input int leaves);
        int c;
        int l;
        c = leaves;
        l = 0;
        while (c > 1) begin
            c = (c + 3) >> 2;
            l++;
        end
        return l;
    endfunction

    // Index of the first node of a level in the flat node array.
    function automatic int tree_level_offset(input int leaves, input int level);
        int o;
        o = 0;
        for (int k = 0; k < level; k++) begin
            o = o + tree_level_count(leaves, k);
        end
        return o;
    endfunction

endpackage

/* sv/mfe_cell.sv */
// ============================================================================
// mfe_cell: one slot of the sorted chain
// Holds one stored value, compares it with the broadcast value when a
// transaction is accepted, and shifts toward or away from its neighbors to
// insert a value or close the gap of an extracted one.
// ============================================================================
module mfe_cell #(
    parameter int VALUE_BITS = 32,
    parameter int FOUND_BITS = 32,
    parameter int OCC_BITS   = 11,
    parameter int INDEX      = 0
) (
    input  logic                  aclk,
    input  mfe_pkg::cell_ctl_t    ctl,
    input  logic [VALUE_BITS-1:0] cmp_value,    // value of the incoming transaction
    input  logic [VALUE_BITS-1:0] ins_value,    // value held for the shift cycle
    input  logic [OCC_BITS-1:0]   occ,
    input  logic [VALUE_BITS-1:0] left_value,
    input  logic                  left_le,
    input  logic [VALUE_BITS-1:0] right_value,
    input  logic                  right_le,
    output logic [VALUE_BITS-1:0] value_out,
    output logic                  le_out,
    output logic [FOUND_BITS-1:0] cand_out
);
    import mfe_pkg::*;

    logic [VALUE_BITS-1:0] value_reg;
    logic [VALUE_BITS-1:0] value_next;
    logic                  le_reg;
    logic                  le_next;
    logic                  in_use;
    logic                  at_pos;
    logic                  after_pos;

    // The cell takes part only while it lies below the fill level.
    assign in_use = (OCC_BITS'(INDEX) < occ);

    // Compare flag: this used cell holds a value not above the broadcast one.
    always_comb begin
        le_next = le_reg;
        if (ctl.cmp_en) begin
            le_next = in_use && (value_reg <= cmp_value);
        end
    end

    // Insert position is the first cell whose flag is clear; cells past it move up.
    assign at_pos    = !le_reg && left_le;
    assign after_pos = !left_le;

    // Shift update of the stored value.
    always_comb begin
        value_next = value_reg;
        if (ctl.ins_en) begin
            if (at_pos) begin
                value_next = ins_value;
            end else if (after_pos) begin
                value_next = left_value;
            end
        end else if (ctl.del_en) begin
            if (!right_le) begin
                value_next = right_value;
            end
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
        le_reg    <= le_next;
    end

    // The last cell with its flag set holds the floor of the query.
    assign cand_out  = (le_reg && !right_le) ? FOUND_BITS'(value_reg) : '0;
    assign value_out = value_reg;
    assign le_out    = le_reg;

endmodule

/* sv/mfe_or_tree.sv */
// ============================================================================
// mfe_or_tree: pipelined radix-4 OR reduction
// Captures one candidate per cell, at most one of them nonzero, and merges
// them through registered levels of four-input OR gates into a single word.
// ============================================================================
module mfe_or_tree #(
    parameter int LEAVES = 1024,
    parameter int WIDTH  = 32
) (
    input  logic             aclk,
    input  logic             load,
    input  logic [WIDTH-1:0] leaf_in [LEAVES],
    output logic [WIDTH-1:0] root
);
    import mfe_pkg::*;

    localparam int LEVELS = tree_levels(LEAVES);
    localparam int NODES  = tree_level_offset(LEAVES, LEVELS + 1);

    logic [WIDTH-1:0] node_reg [NODES];

    // Leaf level, loaded in the shift cycle of a query.
    for (genvar i = 0; i < LEAVES; i++) begin : g_leaf
        always_ff @(posedge aclk) begin
            if (load) begin
                node_reg[i] <= leaf_in[i];
            end
        end
    end

    // Reduction levels, one register stage each.
    for (genvar lv = 1; lv <= LEVELS; lv++) begin : g_level
        localparam int CNT      = tree_level_count(LEAVES, lv);
        localparam int OFF      = tree_level_offset(LEAVES, lv);
        localparam int PREV_CNT = tree_level_count(LEAVES, lv - 1);
        localparam int PREV_OFF = tree_level_offset(LEAVES, lv - 1);
        for (genvar j = 0; j < CNT; j++) begin : g_node
            logic [WIDTH-1:0] merged;
            always_comb begin
                merged = '0;
                for (int m = 0; m < 4; m++) begin
                    if (4 * j + m < PREV_CNT) begin
                        merged = merged | node_reg[PREV_OFF + 4 * j + m];
                    end
                end
            end
            always_ff @(posedge aclk) begin
                node_reg[OFF + j] <= merged;
            end
        end
    end

    assign root = node_reg[NODES-1];

endmodule

/* sv/multiset_floor_extract_core.sv */
// ============================================================================
// multiset_floor_extract_core: sorted multiset with floor extraction
// Keeps up to CAPACITY values in ascending order in a chain of cells.
// An insert transaction opens a gap and writes its value; a query
// transaction removes the largest stored value not above its limit.
// ============================================================================
//
// Channel   Direction  Fields (lowest bit first)
// s_*       in         tuser: action; tdata: value
// m_*       out        tuser: status; tdata: found_value
//
// Every transaction is first accepted and compared in all cells at once.
// An insert then shifts the chain; a query shifts the chain and loads the
// radix-4 tree, whose L registered levels (L = 5 for 1024 cells) collect
// the extracted value before the result is written. The output register
// frees the input side: a new transaction is taken while a result still waits.
// Reset is synchronous and clears the controller, the fill count and the
// output valid; the cells need no clearing. A stall on m_tready holds the
// controller in its output state until the register is free.
// ============================================================================
module multiset_floor_extract_core #(
    parameter int CAPACITY   = mfe_pkg::DEF_CAPACITY,
    parameter int VALUE_BITS = mfe_pkg::DEF_VALUE_BITS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,    // [31:0] value
    input  logic [0:0]  s_tuser,    // [0] action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // [31:0] found_value
    output logic [1:0]  m_tuser     // [1:0] status
);
    import mfe_pkg::*;

    localparam int OCC_BITS    = $clog2(CAPACITY + 1);
    localparam int FOUND_BITS  = (VALUE_BITS < VALUE_FIELD_BITS) ? VALUE_BITS
                                                                 : VALUE_FIELD_BITS;
    localparam int TREE_LEVELS = tree_levels(CAPACITY);
    localparam int CNT_BITS    = $clog2(TREE_LEVELS + 1);

    state_t                         state_reg, state_next;
    logic                           op_reg, op_next;
    logic [VALUE_BITS-1:0]          val_reg, val_next;
    logic [OCC_BITS-1:0]            occ_reg, occ_next;
    logic [CNT_BITS-1:0]            cnt_reg, cnt_next;
    logic [STATUS_FIELD_BITS-1:0]   status_reg, status_next;
    logic                           m_tvalid_reg, m_tvalid_next;
    logic [VALUE_FIELD_BITS-1:0]    m_tdata_reg, m_tdata_next;
    logic [STATUS_FIELD_BITS-1:0]   m_tuser_reg, m_tuser_next;

    logic                           accept;
    logic                           full;
    logic                           out_free;
    logic                           out_load;
    logic                           tree_load;
    logic [STATUS_FIELD_BITS-1:0]   shift_status;
    logic [STATUS_FIELD_BITS-1:0]   out_status;
    logic [VALUE_FIELD_BITS-1:0]    out_found;
    logic [VALUE_BITS-1:0]          s_value;
    cell_ctl_t                      ctl;

    logic [VALUE_BITS-1:0]          cell_value [CAPACITY];
    logic                           cell_le    [CAPACITY];
    logic [FOUND_BITS-1:0]          cell_cand  [CAPACITY];
    logic [FOUND_BITS-1:0]          tree_root;

    assign s_value  = VALUE_BITS'(s_tdata);
    assign accept   = s_tvalid && s_tready;
    assign full     = (occ_reg == OCC_BITS'(CAPACITY));
    assign out_free = !m_tvalid_reg || m_tready;

    // Status of the current transaction, known in the shift cycle.
    always_comb begin
        if (op_reg == ACTION_INSERT) begin
            shift_status = full ? STATUS_FULL : STATUS_INSERTED;
        end else begin
            shift_status = cell_le[0] ? STATUS_FOUND : STATUS_NONE;
        end
    end

    // Controller next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_SHIFT;
                end
            end
            ST_SHIFT: begin
                if (op_reg == ACTION_QUERY) begin
                    state_next = ST_TREE;
                end else if (out_free) begin
                    state_next = ST_IDLE;
                end else begin
                    state_next = ST_OUT;
                end
            end
            ST_TREE: begin
                if (cnt_reg == CNT_BITS'(TREE_LEVELS - 1)) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Controller outputs.
    always_comb begin
        s_tready   = 1'b0;
        ctl        = '0;
        tree_load  = 1'b0;
        out_load   = 1'b0;
        out_status = status_reg;
        out_found  = '0;
        case (state_reg)
            ST_IDLE: begin
                s_tready   = 1'b1;
                ctl.cmp_en = s_tvalid;
            end
            ST_SHIFT: begin
                ctl.ins_en = (op_reg == ACTION_INSERT) && !full;
                ctl.del_en = (op_reg == ACTION_QUERY) && cell_le[0];
                tree_load  = (op_reg == ACTION_QUERY);
                out_load   = (op_reg == ACTION_INSERT) && out_free;
                out_status = shift_status;
            end
            ST_TREE: begin
                out_load = 1'b0;
            end
            ST_OUT: begin
                out_load = out_free;
                if (status_reg == STATUS_FOUND) begin
                    out_found = VALUE_FIELD_BITS'(tree_root);
                end
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    // Transaction registers, fill count and tree wait counter.
    always_comb begin
        op_next     = op_reg;
        val_next    = val_reg;
        occ_next    = occ_reg;
        cnt_next    = cnt_reg;
        status_next = status_reg;
        if (accept) begin
            op_next  = s_tuser[0];
            val_next = s_value;
        end
        if (state_reg == ST_SHIFT) begin
            status_next = shift_status;
            cnt_next    = '0;
        end
        if (state_reg == ST_TREE) begin
            cnt_next = cnt_reg + 1'b1;
        end
        if (ctl.ins_en) begin
            occ_next = occ_reg + 1'b1;
        end else if (ctl.del_en) begin
            occ_next = occ_reg - 1'b1;
        end
    end

    // Output register.
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        if (out_load) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = out_found;
            m_tuser_next  = out_status;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            occ_reg      <= '0;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            occ_reg      <= occ_next;
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg      <= op_next;
        val_reg     <= val_next;
        status_reg  <= status_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    // Chain of cells, lowest value at index zero.
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [VALUE_BITS-1:0] left_value;
        logic                  left_le;
        logic [VALUE_BITS-1:0] right_value;
        logic                  right_le;

        if (i == 0) begin : g_first
            assign left_value = '0;
            assign left_le    = 1'b1;
        end else begin : g_inner_left
            assign left_value = cell_value[i-1];
            assign left_le    = cell_le[i-1];
        end

        if (i == CAPACITY - 1) begin : g_last
            assign right_value = '0;
            assign right_le    = 1'b0;
        end else begin : g_inner_right
            assign right_value = cell_value[i+1];
            assign right_le    = cell_le[i+1];
        end

        mfe_cell #(
            .VALUE_BITS (VALUE_BITS),
            .FOUND_BITS (FOUND_BITS),
            .OCC_BITS   (OCC_BITS),
            .INDEX      (i)
        ) u_cell (
            .aclk        (aclk),
            .ctl         (ctl),
            .cmp_value   (s_value),
            .ins_value   (val_reg),
            .occ         (occ_reg),
            .left_value  (left_value),
            .left_le     (left_le),
            .right_value (right_value),
            .right_le    (right_le),
            .value_out   (cell_value[i]),
            .le_out      (cell_le[i]),
            .cand_out    (cell_cand[i])
        );
    end

    // Collects the extracted value from the one selected cell.
    mfe_or_tree #(
        .LEAVES (CAPACITY),
        .WIDTH  (FOUND_BITS)
    ) u_tree (
        .aclk    (aclk),
        .load    (tree_load),
        .leaf_in (cell_cand),
        .root    (tree_root)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule
